FILE: design/u8dec_pkg.sv
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types, constants and the byte classifier of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int BYTE_W       = 8;
  localparam int CP_W         = 21;
  localparam int PEND_DEPTH   = 4;
  localparam int PEND_CNT_W   = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_CNT_W  = 2;

  localparam logic [CP_W-1:0]   REPLACEMENT = 21'h00FFFD;
  localparam logic [BYTE_W-1:0] MASK_2BYTE  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_2BYTE  = 8'hC0;
  localparam logic [BYTE_W-1:0] MASK_3BYTE  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_3BYTE  = 8'hE0;
  localparam logic [BYTE_W-1:0] MASK_4BYTE  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD_4BYTE  = 8'hF0;
  localparam logic [BYTE_W-1:0] MASK_CONT   = 8'hC0;
  localparam logic [BYTE_W-1:0] TAG_CONT    = 8'h80;
  localparam logic [BYTE_W-1:0] PAYLOAD_6   = 8'h3F;

  typedef struct packed {
    logic       invalid;
    logic       cont;
    logic [1:0] extra;
  } cls_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eot;
    cls_t              cls;
  } item_t;

  typedef enum logic {
    BK_IDLE,
    BK_DECODE
  } back_state_t;

  function automatic cls_t classify(input logic [BYTE_W-1:0] b);
    cls_t c;
    c.cont    = ((b & MASK_CONT) == TAG_CONT);
    c.invalid = 1'b0;
    c.extra   = 2'd0;
    if (!b[BYTE_W-1]) begin
      c.extra = 2'd0;
    end else if ((b & MASK_2BYTE) == LEAD_2BYTE) begin
      c.extra = 2'd1;
    end else if ((b & MASK_3BYTE) == LEAD_3BYTE) begin
      c.extra = 2'd2;
    end else if ((b & MASK_4BYTE) == LEAD_4BYTE) begin
      c.extra = 2'd3;
    end else begin
      c.invalid = 1'b1;
    end
    return c;
  endfunction

endpackage

FILE: design/u8dec_byte_if.sv
// ----------------------------------------------------------------------------
// u8dec_byte_if
// Input channel of the decoder: one raw byte and its end-of-text mark.
// ----------------------------------------------------------------------------
interface u8dec_byte_if;
  logic                         valid;
  logic                         ready;
  logic [u8dec_pkg::BYTE_W-1:0] data_byte;
  logic                         end_of_text;

  modport source(output valid, output data_byte, output end_of_text, input ready);
  modport sink(input valid, input data_byte, input end_of_text, output ready);
endinterface

FILE: design/u8dec_cp_if.sv
// ----------------------------------------------------------------------------
// u8dec_cp_if
// Output channel of the decoder: one code point with its status flags.
// ----------------------------------------------------------------------------
interface u8dec_cp_if;
  logic                       valid;
  logic                       ready;
  logic [u8dec_pkg::CP_W-1:0] code_point;
  logic                       bad_sequence;
  logic                       run_last;

  modport source(output valid, output code_point, output bad_sequence,
                 output run_last, input ready);
  modport sink(input valid, input code_point, input bad_sequence,
               input run_last, output ready);
endinterface

FILE: design/u8dec_front.sv
// ----------------------------------------------------------------------------
// u8dec_front
// Accepts input bytes, classifies each one and holds it in a register stage.
// ----------------------------------------------------------------------------
module u8dec_front (
  input  logic             clk,
  input  logic             rst,
  u8dec_byte_if.sink       byte_stream,
  output logic             item_valid,
  output u8dec_pkg::item_t item,
  input  logic             item_ready
);

  logic take;

  assign byte_stream.ready = !item_valid || item_ready;
  assign take              = byte_stream.valid && byte_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.data <= byte_stream.data_byte;
      item.eot  <= byte_stream.end_of_text;
      item.cls  <= u8dec_pkg::classify(byte_stream.data_byte);
    end
  end

endmodule

FILE: design/u8dec_queue.sv
// ----------------------------------------------------------------------------
// u8dec_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module u8dec_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  input  u8dec_pkg::item_t wr_item,
  output logic             wr_ready,
  output logic             rd_valid,
  output u8dec_pkg::item_t rd_item,
  input  logic             rd_ready
);

  u8dec_pkg::item_t                  mem [u8dec_pkg::QUEUE_DEPTH];
  logic                              wr_ptr;
  logic                              rd_ptr;
  logic [u8dec_pkg::QUEUE_CNT_W-1:0] fill;
  logic                              push;
  logic                              pop;

  assign wr_ready = (fill != u8dec_pkg::QUEUE_CNT_W'(u8dec_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_item  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

FILE: design/u8dec_back.sv
// ----------------------------------------------------------------------------
// u8dec_back
// Keeps the pending bytes and, in its decode state while the output register
// is free, decides one result per cycle into the output register.
// ----------------------------------------------------------------------------
module u8dec_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  u8dec_pkg::item_t item,
  output logic             item_ready,
  u8dec_cp_if.source       code_stream
);

  localparam int CW = u8dec_pkg::PEND_CNT_W;

  u8dec_pkg::back_state_t       state;
  u8dec_pkg::back_state_t       state_next;
  logic [u8dec_pkg::BYTE_W-1:0] pend [u8dec_pkg::PEND_DEPTH];
  u8dec_pkg::cls_t              pcls [u8dec_pkg::PEND_DEPTH];
  logic [u8dec_pkg::BYTE_W-1:0] pend_shift [u8dec_pkg::PEND_DEPTH];
  u8dec_pkg::cls_t              pcls_shift [u8dec_pkg::PEND_DEPTH];
  logic [CW-1:0]                count;
  logic                         eot;

  u8dec_pkg::cls_t              head;
  u8dec_pkg::cls_t              next_head;
  logic [CW-1:0]                need;
  logic                         decidable;
  logic                         cont_ok;
  logic                         have_result;
  logic                         slot_free;
  logic                         fire;
  logic [CW-1:0]                drop;
  logic [CW-1:0]                count_left;
  logic [u8dec_pkg::CP_W-1:0]   res_cp;
  logic                         res_bad;
  logic                         res_last;
  logic                         pop;

  assign item_ready = (state == u8dec_pkg::BK_IDLE);
  assign pop        = item_valid && item_ready;
  assign slot_free  = !code_stream.valid || code_stream.ready;

  assign head      = pcls[0];
  assign need      = CW'(head.extra) + 1'b1;
  assign decidable = head.invalid || (need <= count);
  assign cont_ok   = ((head.extra < 2'd1) || pcls[1].cont) &&
                     ((head.extra < 2'd2) || pcls[2].cont) &&
                     ((head.extra < 2'd3) || pcls[3].cont);
  assign have_result = (count != '0) && (decidable || eot);

  always_comb begin
    res_bad = 1'b1;
    res_cp  = u8dec_pkg::REPLACEMENT;
    drop    = CW'(1);
    if (head.invalid) begin
      drop = CW'(1);
    end else if (decidable) begin
      if (cont_ok) begin
        res_bad = 1'b0;
        drop    = need;
        case (head.extra)
          2'd0: res_cp = u8dec_pkg::CP_W'(pend[0]);
          2'd1: res_cp = u8dec_pkg::CP_W'({pend[0][4:0], pend[1][5:0]});
          2'd2: res_cp = u8dec_pkg::CP_W'({pend[0][3:0], pend[1][5:0], pend[2][5:0]});
          2'd3: res_cp = {pend[0][2:0], pend[1][5:0], pend[2][5:0], pend[3][5:0]};
          default: res_cp = u8dec_pkg::REPLACEMENT;
        endcase
      end
    end else begin
      drop = count;
    end
  end

  assign count_left = count - drop;
  assign next_head  = pcls[drop[1:0]];

  always_comb begin
    if (count_left == '0) begin
      res_last = 1'b1;
    end else if (eot) begin
      res_last = 1'b0;
    end else begin
      res_last = !next_head.invalid && ((CW'(next_head.extra) + 1'b1) > count_left);
    end
  end

  always_comb begin
    logic [CW-1:0] idx;
    idx = '0;
    for (int i = 0; i < u8dec_pkg::PEND_DEPTH; i++) begin
      idx           = CW'(i) + drop;
      pend_shift[i] = pend[idx[1:0]];
      pcls_shift[i] = pcls[idx[1:0]];
    end
  end

  assign fire = (state == u8dec_pkg::BK_DECODE) && have_result && slot_free;

  always_comb begin
    state_next = state;
    case (state)
      u8dec_pkg::BK_IDLE: begin
        if (pop) begin
          state_next = u8dec_pkg::BK_DECODE;
        end
      end
      u8dec_pkg::BK_DECODE: begin
        if (!have_result) begin
          state_next = u8dec_pkg::BK_IDLE;
        end else if (fire && res_last) begin
          state_next = u8dec_pkg::BK_IDLE;
        end
      end
      default: state_next = u8dec_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= u8dec_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count             <= '0;
      eot               <= 1'b0;
      code_stream.valid <= 1'b0;
    end else begin
      if (pop) begin
        count <= count + 1'b1;
        eot   <= item.eot;
      end else if (fire) begin
        count <= count_left;
      end
      if (fire) begin
        code_stream.valid <= 1'b1;
      end else if (code_stream.ready) begin
        code_stream.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend[count[1:0]] <= item.data;
      pcls[count[1:0]] <= item.cls;
    end else if (fire) begin
      for (int i = 0; i < u8dec_pkg::PEND_DEPTH; i++) begin
        pend[i] <= pend_shift[i];
        pcls[i] <= pcls_shift[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      code_stream.code_point   <= res_cp;
      code_stream.bad_sequence <= res_bad;
      code_stream.run_last     <= res_last;
    end
  end

endmodule

FILE: design/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Streaming UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
// Bytes enter through a classifying register stage and a two-entry queue, so
// input transfers continue while the decoder works or the output stalls. The
// decoder takes a byte into its pending buffer, then, while the output
// register is free, produces one code point per cycle for each result it
// completes; no new byte is taken while it decodes. A byte that cannot lead a
// sequence, a missing continuation or truncated input yields U+FFFD with
// bad_sequence set, and run_last marks the final result caused by a byte.
module utf8_stream_decoder_top (
  input  logic       clk,
  input  logic       rst,
  u8dec_byte_if.sink  byte_stream,
  u8dec_cp_if.source  code_stream
);

  logic             f_valid;
  u8dec_pkg::item_t f_item;
  logic             f_ready;
  logic             q_valid;
  u8dec_pkg::item_t q_item;
  logic             q_ready;

  u8dec_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_stream(byte_stream),
    .item_valid (f_valid),
    .item       (f_item),
    .item_ready (f_ready)
  );

  u8dec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(f_valid),
    .wr_item (f_item),
    .wr_ready(f_ready),
    .rd_valid(q_valid),
    .rd_item (q_item),
    .rd_ready(q_ready)
  );

  u8dec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .item_ready (q_ready),
    .code_stream(code_stream)
  );

endmodule
